// ===== sv/rlse_pkg.sv =====
`timescale 1ns / 1ps

package rlse_pkg;

    // Default datapath width, Q(W-16).16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;

    // Configuration register indexes
    localparam logic CFG_FORGETTING = 1'b0;
    localparam logic CFG_INIT_COV   = 1'b1;

    // Register reset values
    localparam logic [16:0] LAMBDA_RESET   = 17'd65208;
    localparam logic [30:0] INIT_COV_RESET = 31'd65536000;

    // Micro-operation kinds
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_PASS,
        OP_NEG
    } op_t;

    // Operand / destination addresses: bit 5 selects scratch memory
    localparam logic [5:0] A_P0    = 6'd0;
    localparam logic [5:0] A_P1    = 6'd1;
    localparam logic [5:0] A_P2    = 6'd2;
    localparam logic [5:0] A_P3    = 6'd3;
    localparam logic [5:0] A_TH0   = 6'd4;
    localparam logic [5:0] A_TH1   = 6'd5;
    localparam logic [5:0] A_PHI0  = 6'd6;
    localparam logic [5:0] A_PHI1  = 6'd7;
    localparam logic [5:0] A_Y     = 6'd8;
    localparam logic [5:0] A_LAM   = 6'd9;
    localparam logic [5:0] A_LAST  = 6'd10;
    localparam logic [5:0] A_PPHI0 = 6'd32;
    localparam logic [5:0] A_PPHI1 = 6'd33;
    localparam logic [5:0] A_PTP0  = 6'd34;
    localparam logic [5:0] A_PTP1  = 6'd35;
    localparam logic [5:0] A_DEN   = 6'd36;
    localparam logic [5:0] A_G0    = 6'd37;
    localparam logic [5:0] A_G1    = 6'd38;
    localparam logic [5:0] A_E     = 6'd39;
    localparam logic [5:0] A_KPT0  = 6'd40;
    localparam logic [5:0] A_KPT1  = 6'd41;
    localparam logic [5:0] A_KPT2  = 6'd42;
    localparam logic [5:0] A_KPT3  = 6'd43;
    localparam logic [5:0] A_KP0   = 6'd44;
    localparam logic [5:0] A_KP1   = 6'd45;
    localparam logic [5:0] A_KP2   = 6'd46;
    localparam logic [5:0] A_KP3   = 6'd47;
    localparam logic [5:0] A_SCR   = 6'd48;

    localparam int PROG_LEN = 45;

    typedef struct packed {
        op_t        op;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] dst;
        logic       acc;
    } uop_t;

    // Request from sequencer to the shared multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    function automatic uop_t mk(op_t op, logic [5:0] a, logic [5:0] b,
                                logic [5:0] dst, logic acc);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.dst = dst;
        u.acc = acc;
        return u;
    endfunction

    // One RLS update as a fixed program of micro-operations
    function automatic uop_t prog_rom(logic [5:0] idx);
        uop_t u;
        case (idx)
            6'd0:  u = mk(OP_MUL,  A_P0,   A_PHI0, A_PPHI0, 1'b0);
            6'd1:  u = mk(OP_MUL,  A_P1,   A_PHI1, A_PPHI0, 1'b1);
            6'd2:  u = mk(OP_MUL,  A_P2,   A_PHI0, A_PPHI1, 1'b0);
            6'd3:  u = mk(OP_MUL,  A_P3,   A_PHI1, A_PPHI1, 1'b1);
            6'd4:  u = mk(OP_MUL,  A_PHI0, A_P0,   A_PTP0,  1'b0);
            6'd5:  u = mk(OP_MUL,  A_PHI1, A_P2,   A_PTP0,  1'b1);
            6'd6:  u = mk(OP_MUL,  A_PHI0, A_P1,   A_PTP1,  1'b0);
            6'd7:  u = mk(OP_MUL,  A_PHI1, A_P3,   A_PTP1,  1'b1);
            6'd8:  u = mk(OP_MUL,  A_PTP0, A_PHI0, A_DEN,   1'b0);
            6'd9:  u = mk(OP_MUL,  A_PTP1, A_PHI1, A_DEN,   1'b1);
            6'd10: u = mk(OP_PASS, A_LAM,  A_LAM,  A_DEN,   1'b1);
            6'd11: u = mk(OP_DIV,  A_PPHI0, A_DEN, A_G0,    1'b0);
            6'd12: u = mk(OP_DIV,  A_PPHI1, A_DEN, A_G1,    1'b0);
            6'd13: u = mk(OP_MUL,  A_TH0,  A_PHI0, A_LAST,  1'b0);
            6'd14: u = mk(OP_MUL,  A_TH1,  A_PHI1, A_LAST,  1'b1);
            6'd15: u = mk(OP_PASS, A_Y,    A_Y,    A_E,     1'b0);
            6'd16: u = mk(OP_NEG,  A_LAST, A_LAST, A_E,     1'b1);
            6'd17: u = mk(OP_MUL,  A_G0,   A_PHI0, A_KPT0,  1'b0);
            6'd18: u = mk(OP_MUL,  A_G0,   A_PHI1, A_KPT1,  1'b0);
            6'd19: u = mk(OP_MUL,  A_G1,   A_PHI0, A_KPT2,  1'b0);
            6'd20: u = mk(OP_MUL,  A_G1,   A_PHI1, A_KPT3,  1'b0);
            6'd21: u = mk(OP_MUL,  A_KPT0, A_P0,   A_KP0,   1'b0);
            6'd22: u = mk(OP_MUL,  A_KPT1, A_P2,   A_KP0,   1'b1);
            6'd23: u = mk(OP_MUL,  A_KPT0, A_P1,   A_KP1,   1'b0);
            6'd24: u = mk(OP_MUL,  A_KPT1, A_P3,   A_KP1,   1'b1);
            6'd25: u = mk(OP_MUL,  A_KPT2, A_P0,   A_KP2,   1'b0);
            6'd26: u = mk(OP_MUL,  A_KPT3, A_P2,   A_KP2,   1'b1);
            6'd27: u = mk(OP_MUL,  A_KPT2, A_P1,   A_KP3,   1'b0);
            6'd28: u = mk(OP_MUL,  A_KPT3, A_P3,   A_KP3,   1'b1);
            6'd29: u = mk(OP_PASS, A_TH0,  A_TH0,  A_TH0,   1'b0);
            6'd30: u = mk(OP_MUL,  A_G0,   A_E,    A_TH0,   1'b1);
            6'd31: u = mk(OP_PASS, A_TH1,  A_TH1,  A_TH1,   1'b0);
            6'd32: u = mk(OP_MUL,  A_G1,   A_E,    A_TH1,   1'b1);
            6'd33: u = mk(OP_PASS, A_P0,   A_P0,   A_SCR,   1'b0);
            6'd34: u = mk(OP_NEG,  A_KP0,  A_KP0,  A_SCR,   1'b1);
            6'd35: u = mk(OP_DIV,  A_SCR,  A_LAM,  A_P0,    1'b0);
            6'd36: u = mk(OP_PASS, A_P1,   A_P1,   A_SCR,   1'b0);
            6'd37: u = mk(OP_NEG,  A_KP1,  A_KP1,  A_SCR,   1'b1);
            6'd38: u = mk(OP_DIV,  A_SCR,  A_LAM,  A_P1,    1'b0);
            6'd39: u = mk(OP_PASS, A_P2,   A_P2,   A_SCR,   1'b0);
            6'd40: u = mk(OP_NEG,  A_KP2,  A_KP2,  A_SCR,   1'b1);
            6'd41: u = mk(OP_DIV,  A_SCR,  A_LAM,  A_P2,    1'b0);
            6'd42: u = mk(OP_PASS, A_P3,   A_P3,   A_SCR,   1'b0);
            6'd43: u = mk(OP_NEG,  A_KP3,  A_KP3,  A_SCR,   1'b1);
            6'd44: u = mk(OP_DIV,  A_SCR,  A_LAM,  A_P3,    1'b0);
            default: u = mk(OP_PASS, A_LAST, A_LAST, A_SCR, 1'b0);
        endcase
        return u;
    endfunction

endpackage

// ===== sv/rlse_muldiv.sv =====
`timescale 1ns / 1ps

module rlse_muldiv
    import rlse_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  md_req_t                      req,
    input  logic signed [DATA_WIDTH-1:0] op_a,
    input  logic signed [DATA_WIDTH-1:0] op_b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = W + FRAC_BITS;
    localparam int MW = (PW - FRAC_BITS > NW) ? PW - FRAC_BITS : NW;
    localparam int CW = $clog2(NW + 1);
    localparam logic [MW-1:0] LIM_POS = MW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [MW-1:0] LIM_NEG = MW'(64'd1 << (W - 1));

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_FIN
    } ustate_t;

    ustate_t                st_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   neg_reg;
    logic                   div_reg;
    logic                   dz_reg;
    logic                   nzero_reg;
    logic                   numneg_reg;
    logic [PW-1:0]          prod_reg;
    logic [PW-1:0]          mcand_reg;
    logic [W-1:0]           mplier_reg;
    logic [W-1:0]           rem_reg;
    logic [NW-1:0]          quo_reg;
    logic [W-1:0]           dvsr_reg;
    logic                   done_reg;
    logic signed [W-1:0]    result_reg;

    logic [W-1:0]  ua;
    logic [W-1:0]  ub;
    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;
    logic [MW-1:0] mval;
    logic [MW-1:0] mclip;
    logic [W-1:0]  mres;

    // Operand magnitudes
    assign ua = op_a[W-1] ? W'(-op_a) : W'(op_a);
    assign ub = op_b[W-1] ? W'(-op_b) : W'(op_b);

    // One restoring division step
    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign diff   = (W + 2)'(rem_sh) - (W + 2)'(dvsr_reg);

    // Clip the magnitude and apply the sign
    always_comb begin
        mval  = div_reg ? MW'(quo_reg) : MW'(prod_reg[PW-1:FRAC_BITS]);
        mclip = mval;
        if (neg_reg && mval > LIM_NEG) begin
            mclip = LIM_NEG;
        end else if (!neg_reg && mval > LIM_POS) begin
            mclip = LIM_POS;
        end
        mres = W'(mclip);
        if (neg_reg) begin
            mres = W'(-mres);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= U_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (st_reg)
                U_IDLE: begin
                    if (req.start) begin
                        neg_reg    <= op_a[W-1] ^ op_b[W-1];
                        div_reg    <= req.is_div;
                        numneg_reg <= op_a[W-1];
                        nzero_reg  <= (ua != '0);
                        dz_reg     <= req.is_div && (ub == '0);
                        prod_reg   <= '0;
                        mcand_reg  <= PW'(ua);
                        mplier_reg <= ub;
                        rem_reg    <= '0;
                        quo_reg    <= {ua, {FRAC_BITS{1'b0}}};
                        dvsr_reg   <= ub;
                        cnt_reg    <= req.is_div ? CW'(NW) : CW'(W);
                        st_reg     <= (req.is_div && ub == '0) ? U_FIN : U_RUN;
                    end
                end
                U_RUN: begin
                    // Advance one multiply or divide step
                    if (div_reg) begin
                        if (!diff[W+1]) begin
                            rem_reg <= W'(diff);
                        end else begin
                            rem_reg <= W'(rem_sh);
                        end
                        quo_reg <= {quo_reg[NW-2:0], ~diff[W+1]};
                    end else begin
                        if (mplier_reg[0]) begin
                            prod_reg <= prod_reg + mcand_reg;
                        end
                        mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[W-1:1]};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        st_reg <= U_FIN;
                    end
                end
                U_FIN: begin
                    if (dz_reg) begin
                        if (!nzero_reg) begin
                            result_reg <= '0;
                        end else if (numneg_reg) begin
                            result_reg <= W'(LIM_NEG);
                        end else begin
                            result_reg <= W'(LIM_POS);
                        end
                    end else begin
                        result_reg <= mres;
                    end
                    done_reg <= 1'b1;
                    st_reg   <= U_IDLE;
                end
                default: begin
                    st_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/recursive_least_squares_estimator.sv =====
`timescale 1ns / 1ps

// Two-coefficient recursive least squares estimator with forgetting factor, in
// saturating signed fixed point with 16 fraction bits. Each input beat carries a
// plant output sample, the delayed drive value and an update flag; each beat
// yields exactly one result beat with the a-priori prediction and both
// coefficients. An update runs a fixed 45-step program through one shared
// bit-serial multiply/divide unit: 26 multiplies, 6 divides and 13 add steps,
// then the result is posted and the input reopens. A beat with update_enable
// low skips the program and posts the values held from the last update.
// s_tready is low while an item is in work and while its result waits for a
// full output register to drain. Configuration writes are taken only while
// the block is idle; writing initial_covariance reloads the covariance
// matrix at once.

module recursive_least_squares_estimator
    import rlse_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // measured_output [31:0], delayed_drive [63:32]
    input  logic        s_tuser,   // update_enable
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // predicted_output [31:0], coef_a [63:32], coef_b [95:64]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int W = DATA_WIDTH;
    localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
    localparam logic signed [W-1:0] VMAX = W'(VMAX64);
    localparam logic signed [W-1:0] VMIN = W'(VMIN64);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_WAIT,
        S_DONE
    } state_t;

    function automatic logic signed [W-1:0] sat64(logic signed [63:0] v);
        if (v > VMAX64) begin
            return VMAX;
        end else if (v < VMIN64) begin
            return VMIN;
        end
        return W'(v);
    endfunction

    function automatic logic signed [W-1:0] sat_cov(logic [30:0] v);
        return sat64(64'(v));
    endfunction

    function automatic logic [31:0] low32(logic signed [W-1:0] v);
        logic signed [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

    state_t              st_reg;
    logic [5:0]          step_reg;
    logic signed [W-1:0] acc_reg;
    logic                m_tvalid_reg;
    logic [95:0]         m_tdata_reg;

    logic [16:0]         lambda_reg;
    logic signed [W-1:0] p_reg [4];
    logic signed [W-1:0] th0_reg;
    logic signed [W-1:0] th1_reg;
    logic signed [W-1:0] phi0_reg;
    logic signed [W-1:0] phi1_reg;
    logic signed [W-1:0] y_reg;
    logic signed [W-1:0] last_reg;
    logic signed [W-1:0] prev_out_reg;
    logic signed [W-1:0] prev_drv_reg;

    logic signed [W-1:0] tmp_mem [16];
    logic signed [W-1:0] rda_reg;
    logic signed [W-1:0] rdb_reg;

    uop_t                uop;
    logic signed [W-1:0] pers_a;
    logic signed [W-1:0] pers_b;
    logic signed [W-1:0] op_a;
    logic signed [W-1:0] op_b;
    logic signed [W+1:0] u_val;
    logic signed [W+1:0] sum;
    logic signed [W-1:0] wr_val;
    logic                wr_en;
    logic                in_beat;
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] drv_in;
    md_req_t             md_req;
    logic                md_done;
    logic signed [W-1:0] md_result;

    assign uop     = prog_rom(step_reg);
    assign in_beat = s_tvalid && s_tready;
    assign y_in    = sat64(64'($signed(s_tdata[31:0])));
    assign drv_in  = sat64(64'($signed(s_tdata[63:32])));

    // Select a named state register by address
    function automatic logic signed [W-1:0] pers_sel(logic [5:0] a,
        logic signed [W-1:0] p0, logic signed [W-1:0] p1,
        logic signed [W-1:0] p2, logic signed [W-1:0] p3,
        logic signed [W-1:0] t0, logic signed [W-1:0] t1,
        logic signed [W-1:0] f0, logic signed [W-1:0] f1,
        logic signed [W-1:0] yv, logic [16:0] lam, logic signed [W-1:0] lst);
        case (a)
            A_P0:    return p0;
            A_P1:    return p1;
            A_P2:    return p2;
            A_P3:    return p3;
            A_TH0:   return t0;
            A_TH1:   return t1;
            A_PHI0:  return f0;
            A_PHI1:  return f1;
            A_Y:     return yv;
            A_LAM:   return W'(lam);
            A_LAST:  return lst;
            default: return '0;
        endcase
    endfunction

    always_comb begin
        pers_a = pers_sel(uop.a, p_reg[0], p_reg[1], p_reg[2], p_reg[3], th0_reg, th1_reg,
                          phi0_reg, phi1_reg, y_reg, lambda_reg, last_reg);
        pers_b = pers_sel(uop.b, p_reg[0], p_reg[1], p_reg[2], p_reg[3], th0_reg, th1_reg,
                          phi0_reg, phi1_reg, y_reg, lambda_reg, last_reg);
        op_a   = uop.a[5] ? rda_reg : pers_a;
        op_b   = uop.b[5] ? rdb_reg : pers_b;
    end

    // Scratch memory: registered reads, one write port
    always_ff @(posedge aclk) begin
        rda_reg <= tmp_mem[uop.a[3:0]];
        rdb_reg <= tmp_mem[uop.b[3:0]];
        if (wr_en && uop.dst[5]) begin
            tmp_mem[uop.dst[3:0]] <= wr_val;
        end
    end

    // Form the step result, accumulate and saturate
    always_comb begin
        case (uop.op)
            OP_PASS: u_val = (W + 2)'(op_a);
            OP_NEG:  u_val = -(W + 2)'(op_a);
            default: u_val = (W + 2)'(md_result);
        endcase
        sum = uop.acc ? (W + 2)'(acc_reg) + u_val : u_val;
        if (sum > (W + 2)'(VMAX)) begin
            wr_val = VMAX;
        end else if (sum < (W + 2)'(VMIN)) begin
            wr_val = VMIN;
        end else begin
            wr_val = W'(sum);
        end
        wr_en = ((st_reg == S_EXEC) && (uop.op == OP_PASS || uop.op == OP_NEG))
             || ((st_reg == S_WAIT) && md_done);
        md_req.start  = (st_reg == S_EXEC) && (uop.op == OP_MUL || uop.op == OP_DIV);
        md_req.is_div = (uop.op == OP_DIV);
    end

    rlse_muldiv #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (md_done),
        .result  (md_result)
    );

    // Estimator state, configuration and history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg   <= LAMBDA_RESET;
            p_reg[0]     <= sat_cov(INIT_COV_RESET);
            p_reg[1]     <= '0;
            p_reg[2]     <= '0;
            p_reg[3]     <= sat_cov(INIT_COV_RESET);
            th0_reg      <= '0;
            th1_reg      <= '0;
            last_reg     <= '0;
            prev_out_reg <= '0;
            prev_drv_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FORGETTING: lambda_reg <= cfg_data[16:0];
                    CFG_INIT_COV: begin
                        p_reg[0] <= sat_cov(cfg_data);
                        p_reg[1] <= '0;
                        p_reg[2] <= '0;
                        p_reg[3] <= sat_cov(cfg_data);
                    end
                    default: ;
                endcase
            end
            if (in_beat) begin
                phi0_reg     <= (prev_out_reg == VMIN) ? VMAX : -prev_out_reg;
                phi1_reg     <= prev_drv_reg;
                y_reg        <= y_in;
                prev_out_reg <= y_in;
                prev_drv_reg <= drv_in;
            end
            if (wr_en && !uop.dst[5]) begin
                case (uop.dst)
                    A_P0:    p_reg[0] <= wr_val;
                    A_P1:    p_reg[1] <= wr_val;
                    A_P2:    p_reg[2] <= wr_val;
                    A_P3:    p_reg[3] <= wr_val;
                    A_TH0:   th0_reg  <= wr_val;
                    A_TH1:   th1_reg  <= wr_val;
                    A_LAST:  last_reg <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    // Sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= S_IDLE;
            step_reg     <= '0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (wr_en) begin
                acc_reg <= wr_val;
                if (step_reg == 6'(PROG_LEN - 1)) begin
                    st_reg <= S_DONE;
                end else begin
                    step_reg <= step_reg + 6'd1;
                    st_reg   <= S_FETCH;
                end
            end else begin
                case (st_reg)
                    S_IDLE: begin
                        if (in_beat) begin
                            step_reg <= '0;
                            st_reg   <= s_tuser ? S_FETCH : S_DONE;
                        end
                    end
                    S_FETCH: st_reg <= S_EXEC;
                    S_EXEC:  st_reg <= S_WAIT;
                    S_WAIT:  st_reg <= S_WAIT;
                    S_DONE: begin
                        // Hold the result until the output slot is free
                        if (!m_tvalid_reg || m_tready) begin
                            m_tdata_reg  <= {low32(th1_reg), low32(th0_reg), low32(last_reg)};
                            m_tvalid_reg <= 1'b1;
                            st_reg       <= S_IDLE;
                        end
                    end
                    default: st_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign s_tready  = (st_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = (st_reg == S_IDLE);

endmodule

// ===== sv/rlse_checker.sv =====
`timescale 1ns / 1ps

module rlse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // A pending result beat stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped before acceptance");

    // A pending result beat keeps its payload
    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // An accepted input beat closes the input until its work is done
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // No result is offered out of reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind recursive_least_squares_estimator rlse_checker u_rlse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
